/* src/pdz_pkg.sv */
// Shared constants for the pad dead zone and button edge block.
// No dependencies; imported by the top level, its checker and the testbench.
package pdz_pkg;

  localparam int BUTTON_BITS   = 32;
  localparam int AXIS_BITS     = 16;
  localparam int NUM_AXES      = 4;
  localparam int AX_IDX_BITS   = $clog2(NUM_AXES);
  localparam int DZ_BITS       = AXIS_BITS - 1;
  localparam int DIV_STEPS     = AXIS_BITS - 1;
  localparam int DIV_CNT_BITS  = $clog2(DIV_STEPS);
  localparam int IN_DATA_BITS  = BUTTON_BITS + NUM_AXES * AXIS_BITS;
  localparam int OUT_DATA_BITS = 3 * BUTTON_BITS + NUM_AXES * AXIS_BITS;

  localparam logic [DZ_BITS-1:0]   DZ_RESET   = DZ_BITS'(3932);
  localparam logic [AXIS_BITS:0]   AXIS_FULL  = (AXIS_BITS + 1)'(1) << (AXIS_BITS - 1);
  localparam logic [AXIS_BITS-2:0] AXIS_MAX   = '1;
  localparam logic [AXIS_BITS-1:0] AXIS_MOST_NEG = AXIS_FULL[AXIS_BITS-1:0];

endpackage

/* src/pad_deadzone_and_button_edges.sv */
// Top level: controller poll dead zone rescale and button edge detection.
// Depends on pdz_pkg.
//
// Each accepted poll gets bookkeeping on accept and on completion plus, per
// stick axis, one load, fifteen steps of a shared restoring divider that
// produces one quotient bit per cycle, and one store, with the four axes
// worked in turn through that single divider. An axis at or inside the dead
// zone skips the divider. A failed read skips the divider and all axis work.
// s_tready is high only while the sequencer is idle; a finished result sits
// in the output register so the next poll can be taken while it waits, and a
// result that cannot yet move into a stalled output register holds the
// sequencer in its last step. The dead zone register is written through the
// cfg channel and should change only while no poll is in flight.
module pad_deadzone_and_button_edges
  import pdz_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [DZ_BITS-1:0]       cfg_data,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  // buttons_now, left_x, left_y, right_x, right_y
  input  logic [IN_DATA_BITS-1:0]  s_tdata,
  // read_ok
  input  logic                     s_tuser,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  // held_mask, pressed_mask, released_mask, out_left_x, out_left_y,
  // out_right_x, out_right_y
  output logic [OUT_DATA_BITS-1:0] m_tdata,
  // connected
  output logic                     m_tuser
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_LOAD  = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_STORE = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]              state;
  logic [DZ_BITS-1:0]      dead_zone;
  logic [BUTTON_BITS-1:0]  last_held;
  logic [BUTTON_BITS-1:0]  held;
  logic [BUTTON_BITS-1:0]  pressed;
  logic [BUTTON_BITS-1:0]  released;
  logic                    connected;
  logic [AXIS_BITS-1:0]    axis_in  [NUM_AXES];
  logic [AXIS_BITS-1:0]    axis_res [NUM_AXES];
  logic [AX_IDX_BITS-1:0]  ax;
  logic                    neg;
  logic [AXIS_BITS-1:0]    rem;
  logic [AXIS_BITS-2:0]    quot;
  logic [DIV_CNT_BITS-1:0] cnt;

  logic                    s_accept;
  logic                    out_free;
  logic [BUTTON_BITS-1:0]  held_in;
  logic [AXIS_BITS-1:0]    raw;
  logic [AXIS_BITS:0]      raw_ext;
  logic [AXIS_BITS:0]      mag;
  logic [AXIS_BITS:0]      dz_ext;
  logic [AXIS_BITS:0]      mag_minus_dz;
  logic [AXIS_BITS-1:0]    den;
  logic [AXIS_BITS:0]      rem2;
  logic [AXIS_BITS:0]      rem_diff;
  logic                    rem_ge;
  logic [AXIS_BITS-1:0]    quot_ext;
  logic [AXIS_BITS-1:0]    signed_res;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign s_accept  = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign held_in   = s_tuser ? s_tdata[BUTTON_BITS-1:0] : '0;

  assign raw          = axis_in[ax];
  assign raw_ext      = {raw[AXIS_BITS-1], raw};
  assign mag          = raw[AXIS_BITS-1] ? ((AXIS_BITS + 1)'(0) - raw_ext) : raw_ext;
  assign dz_ext       = {2'b00, dead_zone};
  assign mag_minus_dz = mag - dz_ext;
  assign den          = AXIS_BITS'(AXIS_FULL - dz_ext);
  assign rem2         = {rem, 1'b0};
  assign rem_diff     = rem2 - {1'b0, den};
  assign rem_ge       = (rem2 >= {1'b0, den});
  assign quot_ext     = {1'b0, quot};
  assign signed_res   = neg ? (AXIS_BITS'(0) - quot_ext) : quot_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      m_tvalid  <= 1'b0;
      dead_zone <= DZ_RESET;
      last_held <= '0;
      ax        <= '0;
      cnt       <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        dead_zone <= cfg_data;
      end
      if (state == ST_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_accept) begin
            last_held <= held_in;
            ax        <= '0;
            state     <= s_tuser ? ST_LOAD : ST_DONE;
          end
        end
        ST_LOAD: begin
          cnt   <= '0;
          state <= (mag <= dz_ext || mag[AXIS_BITS]) ? ST_STORE : ST_DIV;
        end
        ST_DIV: begin
          cnt <= cnt + 1'b1;
          if (cnt == DIV_CNT_BITS'(DIV_STEPS - 1)) begin
            state <= ST_STORE;
          end
        end
        ST_STORE: begin
          ax    <= ax + 1'b1;
          state <= (ax == AX_IDX_BITS'(NUM_AXES - 1)) ? ST_DONE : ST_LOAD;
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (s_accept) begin
          connected <= s_tuser;
          held      <= held_in;
          pressed   <= held_in & ~last_held;
          released  <= last_held & ~held_in;
          for (int i = 0; i < NUM_AXES; i++) begin
            axis_in[i] <= s_tdata[BUTTON_BITS + i*AXIS_BITS +: AXIS_BITS];
          end
        end
      end
      ST_LOAD: begin
        neg <= raw[AXIS_BITS-1];
        rem <= mag_minus_dz[AXIS_BITS-1:0];
        if (mag <= dz_ext) begin
          quot <= '0;
        end else if (mag[AXIS_BITS]) begin
          quot <= AXIS_MAX;
        end
      end
      ST_DIV: begin
        if (rem_ge) begin
          rem  <= rem_diff[AXIS_BITS-1:0];
          quot <= {quot[AXIS_BITS-3:0], 1'b1};
        end else begin
          rem  <= rem2[AXIS_BITS-1:0];
          quot <= {quot[AXIS_BITS-3:0], 1'b0};
        end
      end
      ST_STORE: begin
        axis_res[ax] <= signed_res;
      end
      ST_DONE: begin
        if (out_free) begin
          m_tuser                     <= connected;
          m_tdata[BUTTON_BITS-1:0]    <= held;
          m_tdata[BUTTON_BITS +: BUTTON_BITS]   <= pressed;
          m_tdata[2*BUTTON_BITS +: BUTTON_BITS] <= released;
          for (int i = 0; i < NUM_AXES; i++) begin
            m_tdata[3*BUTTON_BITS + i*AXIS_BITS +: AXIS_BITS] <=
              connected ? axis_res[i] : '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

/* src/pdz_checker.sv */
// Port-level checker for the pad dead zone and button edge block, with bind.
// Depends on pdz_pkg and the top level's port list.
module pdz_checker
  import pdz_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     s_tvalid,
  input logic                     s_tready,
  input logic                     m_tvalid,
  input logic                     m_tready,
  input logic [OUT_DATA_BITS-1:0] m_tdata,
  input logic                     m_tuser
);

  logic [BUTTON_BITS-1:0] held;
  logic [BUTTON_BITS-1:0] pressed;
  logic [BUTTON_BITS-1:0] released;

  assign held     = m_tdata[BUTTON_BITS-1:0];
  assign pressed  = m_tdata[BUTTON_BITS +: BUTTON_BITS];
  assign released = m_tdata[2*BUTTON_BITS +: BUTTON_BITS];

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while a poll is in progress");

  a_disconnected_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> held == '0 && pressed == '0 &&
      m_tdata[OUT_DATA_BITS-1:3*BUTTON_BITS] == '0)
    else $error("disconnected result carries buttons or axes");

  a_edges_consistent: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (pressed & ~held) == '0 && (released & held) == '0)
    else $error("edge masks disagree with held mask");

  a_axis_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[3*BUTTON_BITS +: AXIS_BITS] != AXIS_MOST_NEG &&
      m_tdata[3*BUTTON_BITS + AXIS_BITS +: AXIS_BITS] != AXIS_MOST_NEG &&
      m_tdata[3*BUTTON_BITS + 2*AXIS_BITS +: AXIS_BITS] != AXIS_MOST_NEG &&
      m_tdata[3*BUTTON_BITS + 3*AXIS_BITS +: AXIS_BITS] != AXIS_MOST_NEG)
    else $error("axis result outside symmetric range");

endmodule

bind pad_deadzone_and_button_edges pdz_checker u_pdz_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

/* test/pad_deadzone_and_button_edges_tb.sv */
// Testbench for pad_deadzone_and_button_edges: drives controller polls and
// dead zone writes, predicts every result in-line and checks it on the output.
// Depends on pdz_pkg and the top level in src.
`timescale 1ns / 1ps

module pad_deadzone_and_button_edges_tb;
  import pdz_pkg::*;

  localparam int IDLE_LIMIT   = 4000;
  localparam int HOLD_CYCLES  = 600;
  localparam int DRAIN_CYCLES = 100;

  typedef struct packed {
    logic                               ok;
    logic [BUTTON_BITS-1:0]             buttons;
    logic [NUM_AXES-1:0][AXIS_BITS-1:0] axes;
  } poll_t;

  typedef struct packed {
    logic                               connected;
    logic [BUTTON_BITS-1:0]             held;
    logic [BUTTON_BITS-1:0]             pressed;
    logic [BUTTON_BITS-1:0]             released;
    logic [NUM_AXES-1:0][AXIS_BITS-1:0] axes;
  } pad_out_t;

  typedef enum logic [1:0] {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_MOSTLY} rdy_mode_t;

  logic                     clk;
  logic                     rst;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [DZ_BITS-1:0]       cfg_data;
  logic                     s_tvalid;
  logic                     s_tready;
  logic [IN_DATA_BITS-1:0]  s_tdata;
  logic                     s_tuser;
  logic                     m_tvalid;
  logic                     m_tready;
  logic [OUT_DATA_BITS-1:0] m_tdata;
  logic                     m_tuser;

  pad_out_t               pad_result_q[$];
  logic [DZ_BITS-1:0]     dz_reg;
  logic [BUTTON_BITS-1:0] prev_held;
  logic [BUTTON_BITS-1:0] last_buttons;
  int                     mismatches;
  int                     burst_left;
  logic                   long_hold_req;

  pad_deadzone_and_button_edges i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic logic [AXIS_BITS-1:0] dead_zone_axis(input logic [AXIS_BITS-1:0] raw,
                                                          input logic [DZ_BITS-1:0] dz);
    longint unsigned full, mag, d, s;
    full = 64'd1 << (AXIS_BITS - 1);
    d    = dz;
    mag  = raw[AXIS_BITS-1] ? (2 * full - raw) : raw;
    if (mag <= d) return '0;
    s = ((mag - d) * full) / (full - d);
    if (s > full - 1) s = full - 1;
    if (raw[AXIS_BITS-1]) s = 2 * full - s;
    return s[AXIS_BITS-1:0];
  endfunction

  task automatic predict_poll(input poll_t p);
    pad_out_t r;
    r.connected = p.ok;
    r.held      = p.ok ? p.buttons : '0;
    r.pressed   = r.held & ~prev_held;
    r.released  = prev_held & ~r.held;
    for (int i = 0; i < NUM_AXES; i++)
      r.axes[i] = p.ok ? dead_zone_axis(p.axes[i], dz_reg) : '0;
    prev_held = r.held;
    pad_result_q.push_back(r);
  endtask

  function automatic poll_t make_poll(input logic ok, input logic [BUTTON_BITS-1:0] b,
                                      input int a0, input int a1, input int a2, input int a3);
    poll_t p;
    p.ok      = ok;
    p.buttons = b;
    p.axes[0] = a0[AXIS_BITS-1:0];
    p.axes[1] = a1[AXIS_BITS-1:0];
    p.axes[2] = a2[AXIS_BITS-1:0];
    p.axes[3] = a3[AXIS_BITS-1:0];
    return p;
  endfunction

  function automatic poll_t random_poll();
    poll_t p;
    int    v;
    p.ok = $urandom_range(0, 9) != 0;
    case ($urandom_range(0, 7))
      0:       p.buttons = '0;
      1:       p.buttons = '1;
      2, 3:    p.buttons = $urandom();
      default: begin
        p.buttons = last_buttons ^ (32'h1 << $urandom_range(0, 31));
        if ($urandom_range(0, 1)) p.buttons ^= 32'h1 << $urandom_range(0, 31);
      end
    endcase
    last_buttons = p.buttons;
    for (int i = 0; i < NUM_AXES; i++) begin
      case ($urandom_range(0, 5))
        0, 1: p.axes[i] = AXIS_BITS'($urandom());
        2, 3: begin
          v = int'(dz_reg) + int'($urandom_range(0, 6)) - 3;
          if ($urandom_range(0, 1)) v = -v;
          if (v > 32767) v = 32767;
          if (v < -32768) v = -32768;
          p.axes[i] = v[AXIS_BITS-1:0];
        end
        4: begin
          case ($urandom_range(0, 5))
            0:       v = 0;
            1:       v = 32767;
            2:       v = -32768;
            3:       v = -32767;
            4:       v = 1;
            default: v = -1;
          endcase
          p.axes[i] = v[AXIS_BITS-1:0];
        end
        default: begin
          v = int'($urandom_range(0, 2000)) - 1000;
          p.axes[i] = v[AXIS_BITS-1:0];
        end
      endcase
    end
    return p;
  endfunction

  task automatic offer_poll(input poll_t p);
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {p.axes, p.buttons};
    s_tuser  <= p.ok;
    do @(posedge clk); while (!s_tready);
    predict_poll(p);
  endtask

  task automatic send_paced(input poll_t p);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 2) != 0) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
        if ($urandom_range(0, 4) == 0) repeat ($urandom_range(20, 150)) @(negedge clk);
        else repeat ($urandom_range(0, 20)) @(negedge clk);
      end
    end
    burst_left--;
    offer_poll(p);
  endtask

  task automatic wait_results_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (pad_result_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_dead_zone(input logic [DZ_BITS-1:0] v);
    wait_results_drained();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    dz_reg = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: expected %h, got %h", name, want, got);
    end
  endtask

  always @(posedge clk) begin : result_check
    pad_out_t want, got;
    if (!rst && m_tvalid && m_tready) begin
      got.connected = m_tuser;
      got.held      = m_tdata[BUTTON_BITS-1:0];
      got.pressed   = m_tdata[2*BUTTON_BITS-1:BUTTON_BITS];
      got.released  = m_tdata[3*BUTTON_BITS-1:2*BUTTON_BITS];
      got.axes      = m_tdata[OUT_DATA_BITS-1 -: NUM_AXES*AXIS_BITS];
      if (pad_result_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transaction on output: %h", m_tdata);
      end else begin
        want = pad_result_q.pop_front();
        check_field("connected", want.connected, got.connected);
        check_field("held_mask", want.held, got.held);
        check_field("pressed_mask", want.pressed, got.pressed);
        check_field("released_mask", want.released, got.released);
        check_field("out_left_x", want.axes[0], got.axes[0]);
        check_field("out_left_y", want.axes[1], got.axes[1]);
        check_field("out_right_x", want.axes[2], got.axes[2]);
        check_field("out_right_y", want.axes[3], got.axes[3]);
      end
    end
  end

  initial begin : sink_pacing
    int cyc, hold_left;
    cyc       = 0;
    hold_left = 0;
    m_tready  = 1'b0;
    forever begin
      @(negedge clk);
      cyc++;
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
        m_tready <= 1'b0;
      end else begin
        case (rdy_mode_t'(cyc[9:8]))
          RDY_ALWAYS: m_tready <= 1'b1;
          RDY_COIN:   m_tready <= 1'($urandom_range(0, 1));
          RDY_SPARSE: m_tready <= (cyc % 5) == 0;
          default:    m_tready <= $urandom_range(0, 9) != 0;
        endcase
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic test_directed_polls();
    offer_poll(make_poll(1'b1, 32'h0000_0000, 0, 0, 0, 0));
    offer_poll(make_poll(1'b1, 32'hFFFF_FFFF, 32767, -32768, -32767, 1));
    offer_poll(make_poll(1'b1, 32'h0000_0000, 3932, -3932, 3933, -3933));
    offer_poll(make_poll(1'b1, 32'hA5A5_5A5A, -1, 16384, -16384, 3931));
    offer_poll(make_poll(1'b0, 32'h1234_5678, 32767, -32768, 20000, -20000));
    offer_poll(make_poll(1'b0, 32'hFFFF_FFFF, 5000, -5000, 1, -1));
    offer_poll(make_poll(1'b1, 32'h5A5A_A5A5, 20000, -20000, 32766, -32767));
    offer_poll(make_poll(1'b1, 32'hFFFF_FFFF, 3934, -3934, 32767, -32768));
    offer_poll(make_poll(1'b1, 32'h8000_0001, -3931, 3931, 0, -32768));
    offer_poll(make_poll(1'b0, 32'h0000_0000, 0, 0, 0, 0));
  endtask

  task automatic test_dead_zone_extremes();
    logic [DZ_BITS-1:0] dz_list[6];
    dz_list = '{15'd0, 15'd32767, 15'd1, 15'd16384, 15'd32766, 15'd0};
    dz_list[5] = DZ_BITS'($urandom_range(0, 32767));
    foreach (dz_list[k]) begin
      write_dead_zone(dz_list[k]);
      offer_poll(make_poll(1'b1, $urandom(), 32767, -32768, -32767, 0));
      offer_poll(make_poll(1'b1, $urandom(), int'(dz_list[k]), -int'(dz_list[k]),
                           int'(dz_list[k]) - 1, 1 - int'(dz_list[k])));
      repeat (23) send_paced(random_poll());
    end
  endtask

  task automatic test_random_polls();
    for (int ph = 0; ph < 4; ph++) begin
      if (ph == 2) write_dead_zone(DZ_BITS'($urandom_range(0, 32767)));
      else write_dead_zone(DZ_BITS'($urandom_range(0, 8000)));
      repeat (280) send_paced(random_poll());
    end
  endtask

  task automatic test_output_hold_off();
    write_dead_zone(DZ_RESET);
    long_hold_req = 1'b1;
    repeat (40) offer_poll(random_poll());
  endtask

  task automatic test_sender_pause();
    repeat (15) send_paced(random_poll());
    wait_results_drained();
    repeat (15) send_paced(random_poll());
  endtask

  initial begin
    rst           = 1'b1;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    s_tuser       = 1'b0;
    long_hold_req = 1'b0;
    dz_reg        = DZ_RESET;
    prev_held     = '0;
    last_buttons  = '0;
    mismatches    = 0;
    burst_left    = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_polls();
    test_dead_zone_extremes();
    test_random_polls();
    test_output_hold_off();
    test_sender_pause();

    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
